>>> rtl/spicf_pkg.sv
// Shared constants, result type and command decode for the SPI command framer.
`timescale 1ns / 1ps

package spicf_pkg;

   // Transmit buffer depth; the reply index wraps here.
   localparam int TX_BUFFER_DEPTH = 64;
   localparam int TX_INDEX_W      = $clog2(TX_BUFFER_DEPTH);

   // Command codes
   localparam logic [15:0] CMD_STATUS   = 16'h0002;
   localparam logic [15:0] CMD_FLASH0   = 16'h1FFF;
   localparam logic [15:0] CMD_FLASH1   = 16'h2FFF;
   localparam logic [15:0] CMD_RADIO    = 16'h3EFF;
   localparam logic [15:0] CMD_PROGRESS = 16'h3FFE;
   localparam logic [15:0] CMD_STATS    = 16'h3FFF;

   // Reply source codes
   localparam logic [2:0] SRC_NONE     = 3'd0;
   localparam logic [2:0] SRC_STATUS   = 3'd1;
   localparam logic [2:0] SRC_FLASH0   = 3'd2;
   localparam logic [2:0] SRC_FLASH1   = 3'd3;
   localparam logic [2:0] SRC_RADIO    = 3'd4;
   localparam logic [2:0] SRC_PROGRESS = 3'd5;
   localparam logic [2:0] SRC_STATS    = 3'd6;

   // Release action codes
   localparam logic [1:0] REL_NONE   = 2'd0;
   localparam logic [1:0] REL_FLASH0 = 2'd1;
   localparam logic [1:0] REL_FLASH1 = 2'd2;
   localparam logic [1:0] REL_RADIO  = 2'd3;

   // Header positions and the shortest message
   localparam logic [15:0] POS_LEN_LO  = 16'd1;
   localparam logic [15:0] POS_LEN_HI  = 16'd2;
   localparam logic [15:0] POS_CMD_LO  = 16'd3;
   localparam logic [15:0] POS_CMD_HI  = 16'd4;
   localparam logic [15:0] POS_PAYLOAD = 16'd5;
   localparam logic [15:0] MIN_LENGTH  = 16'd4;

   typedef struct packed {
      logic [2:0]  tx_source;
      logic [5:0]  tx_index;
      logic        packet_start;
      logic [15:0] msg_length;
      logic [15:0] msg_command;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [15:0] data_index;
      logic        message_end;
      logic [1:0]  release_action;
      logic        progress_read;
   } result_type;

   // Map a command to its reply source; SRC_NONE for stored packets.
   function automatic logic [2:0] decode_reply(input logic [15:0] cmd);
      logic [2:0] src;
      case (cmd)
         CMD_STATUS:   src = SRC_STATUS;
         CMD_FLASH0:   src = SRC_FLASH0;
         CMD_FLASH1:   src = SRC_FLASH1;
         CMD_RADIO:    src = SRC_RADIO;
         CMD_PROGRESS: src = SRC_PROGRESS;
         CMD_STATS:    src = SRC_STATS;
         default:      src = SRC_NONE;
      endcase
      return src;
   endfunction

endpackage

>>> rtl/spicf_frame.sv
// Message framing state and single-pass result logic of the SPI command framer.
`timescale 1ns / 1ps

module spicf_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            rx_byte,
   output spicf_pkg::result_type result
);
   import spicf_pkg::*;

   logic [15:0]           byte_count_ff, byte_count_in;
   logic [15:0]           length_ff, length_in;
   logic [15:0]           command_ff, command_in;
   logic                  storing_ff, storing_in;
   logic [2:0]            source_ff, source_in;
   logic [TX_INDEX_W-1:0] index_ff, index_in;

   logic [15:0]           count;
   logic [15:0]           end_at;
   logic [2:0]            src;
   logic [TX_INDEX_W-1:0] index_cur;
   logic [TX_INDEX_W+5:0] index_ext;

   // Work out the next state and the result for the byte at the input
   always_comb begin
      count         = byte_count_ff + 16'd1;
      byte_count_in = count;
      length_in     = length_ff;
      command_in    = command_ff;
      storing_in    = storing_ff;
      source_in     = source_ff;
      index_in      = index_ff;
      src           = SRC_NONE;
      result        = '0;

      // Capture the header fields
      case (count)
         POS_LEN_LO: length_in  = {8'h00, rx_byte};
         POS_LEN_HI: length_in  = {rx_byte, length_ff[7:0]};
         POS_CMD_LO: command_in = {8'h00, rx_byte};
         POS_CMD_HI: begin
            command_in = {rx_byte, command_ff[7:0]};
            src        = decode_reply(command_in);
            if (src != SRC_NONE) begin
               source_in            = src;
               index_in             = '0;
               result.progress_read = (command_in == CMD_PROGRESS);
            end else begin
               storing_in          = 1'b1;
               result.packet_start = 1'b1;
            end
         end
         default: ;
      endcase

      // Pass payload bytes of a stored packet
      if (count >= POS_PAYLOAD && storing_in) begin
         result.data_valid = 1'b1;
         result.data_byte  = rx_byte;
         result.data_index = count - POS_PAYLOAD;
      end

      // Close the message; a short length ends at the command's last byte
      end_at = (length_in < MIN_LENGTH) ? MIN_LENGTH : length_in;
      if (count >= MIN_LENGTH && count == end_at) begin
         result.message_end = 1'b1;
         case (command_in)
            CMD_FLASH0: result.release_action = REL_FLASH0;
            CMD_FLASH1: result.release_action = REL_FLASH1;
            CMD_RADIO:  result.release_action = REL_RADIO;
            default:    result.release_action = REL_NONE;
         endcase
         storing_in    = 1'b0;
         byte_count_in = '0;
         source_in     = SRC_NONE;
         index_in      = '0;
      end

      // Choose the next reply byte and advance the wrapping index
      index_cur = index_in;
      index_ext = {6'd0, index_cur};
      if (source_in != SRC_NONE) begin
         result.tx_source = source_in;
         result.tx_index  = index_ext[5:0];
         index_in = (index_cur == TX_INDEX_W'(TX_BUFFER_DEPTH - 1)) ? '0 : index_cur + 1'b1;
      end

      result.msg_length  = length_in;
      result.msg_command = command_in;
   end

   // Hold state between transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         length_ff     <= '0;
         command_ff    <= '0;
         storing_ff    <= 1'b0;
         source_ff     <= SRC_NONE;
         index_ff      <= '0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         length_ff     <= length_in;
         command_ff    <= command_in;
         storing_ff    <= storing_in;
         source_ff     <= source_in;
         index_ff      <= index_in;
      end
   end

endmodule

>>> rtl/spi_slave_command_framer.sv
// A result appears on the rsp_ side in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; the result register refills in the
// cycle it is taken. req_ready drops only while a result waits and rsp_ready is low.
// Reset (synchronous, active high) clears the byte count, header, reply source
// and index, and empties the result register.
`timescale 1ns / 1ps

module spi_slave_command_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_tx_source,
   output logic [5:0]  rsp_tx_index,
   output logic        rsp_packet_start,
   output logic [15:0] rsp_msg_length,
   output logic [15:0] rsp_msg_command,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_data_index,
   output logic        rsp_message_end,
   output logic [1:0]  rsp_release_action,
   output logic        rsp_progress_read
);
   import spicf_pkg::*;

   logic       accept;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result;
   result_type result_ff;

   // Accept whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   spicf_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   // Track the result register occupancy
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tx_source      = result_ff.tx_source;
   assign rsp_tx_index       = result_ff.tx_index;
   assign rsp_packet_start   = result_ff.packet_start;
   assign rsp_msg_length     = result_ff.msg_length;
   assign rsp_msg_command    = result_ff.msg_command;
   assign rsp_data_valid     = result_ff.data_valid;
   assign rsp_data_byte      = result_ff.data_byte;
   assign rsp_data_index     = result_ff.data_index;
   assign rsp_message_end    = result_ff.message_end;
   assign rsp_release_action = result_ff.release_action;
   assign rsp_progress_read  = result_ff.progress_read;

endmodule

>>> rtl/spicf_checker.sv
// Port-level checks for the SPI command framer, bound to the top level.
`timescale 1ns / 1ps

module spicf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_tx_source,
   input logic [5:0]  rsp_tx_index,
   input logic        rsp_packet_start,
   input logic        rsp_data_valid,
   input logic [7:0]  rsp_data_byte,
   input logic [15:0] rsp_data_index,
   input logic        rsp_message_end,
   input logic [1:0]  rsp_release_action
);
   import spicf_pkg::*;

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_source)
         && $stable(rsp_tx_index) && $stable(rsp_data_index))
      else $error("stalled result changed");

   // An empty result register never blocks input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty result register");

   // Release actions only at message end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_action != REL_NONE |-> rsp_message_end)
      else $error("release action without message end");

   // Packet start never coincides with a reply or a payload byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_start |-> rsp_tx_source == SRC_NONE && !rsp_data_valid)
      else $error("packet start with reply or payload");

   // Idle fields read as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tx_source != SRC_NONE || rsp_tx_index == 6'd0)
         && (rsp_data_valid || (rsp_data_byte == 8'd0 && rsp_data_index == 16'd0)))
      else $error("idle field not zero");

endmodule

bind spi_slave_command_framer spicf_checker u_spicf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_tx_source      (rsp_tx_source),
   .rsp_tx_index       (rsp_tx_index),
   .rsp_packet_start   (rsp_packet_start),
   .rsp_data_valid     (rsp_data_valid),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_data_index     (rsp_data_index),
   .rsp_message_end    (rsp_message_end),
   .rsp_release_action (rsp_release_action)
);
